@@ design/bc_pkg.sv @@
package bc_pkg;

    // field widths
    localparam int RAW_W   = 24;
    localparam int CAL_W   = 16;
    localparam int DT_W    = 25;
    localparam int TEMP_W  = 19;
    localparam int PRES_W  = 32;

    // internal widths
    localparam int MULT_W  = DT_W + CAL_W + 1;      // dt times an unsigned calibration word
    localparam int OFF_W   = 40;                    // offset, full range after correction
    localparam int SENS_W  = 39;                    // sensitivity, full range after correction
    localparam int SQ_W    = 36;                    // square of a temperature distance
    localparam int CORR_W  = 39;                    // scaled squares before the final subtract
    localparam int LO_W    = 20;                    // low slice of the sensitivity
    localparam int HI_W    = SENS_W - LO_W;
    localparam int PLO_W   = RAW_W + 1 + LO_W + 1;
    localparam int PHI_W   = RAW_W + 1 + HI_W;
    localparam int PROD_W  = 64;

    // APB
    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;
    localparam int IDX_W   = 3;

    localparam logic [IDX_W-1:0] REG_SENS_BASE     = 3'd0;
    localparam logic [IDX_W-1:0] REG_OFFSET_BASE   = 3'd1;
    localparam logic [IDX_W-1:0] REG_SENS_TEMPCO   = 3'd2;
    localparam logic [IDX_W-1:0] REG_OFFSET_TEMPCO = 3'd3;
    localparam logic [IDX_W-1:0] REG_REF_TEMP      = 3'd4;
    localparam logic [IDX_W-1:0] REG_TEMP_SLOPE    = 3'd5;

    localparam logic [CAL_W-1:0] RST_SENS_BASE     = 16'd40127;
    localparam logic [CAL_W-1:0] RST_OFFSET_BASE   = 16'd36924;
    localparam logic [CAL_W-1:0] RST_SENS_TEMPCO   = 16'd23317;
    localparam logic [CAL_W-1:0] RST_OFFSET_TEMPCO = 16'd23282;
    localparam logic [CAL_W-1:0] RST_REF_TEMP      = 16'd33464;
    localparam logic [CAL_W-1:0] RST_TEMP_SLOPE    = 16'd28312;

    // temperature thresholds in hundredths of a degree
    localparam logic signed [TEMP_W-1:0] TEMP_REF    = TEMP_W'(2000);
    localparam logic signed [TEMP_W-1:0] TEMP_FRIGID = TEMP_W'(-1500);

    localparam int PIPE_STAGES = 8;

    typedef struct packed {
        logic [CAL_W-1:0] sens_base;
        logic [CAL_W-1:0] offset_base;
        logic [CAL_W-1:0] sens_tempco;
        logic [CAL_W-1:0] offset_tempco;
        logic [CAL_W-1:0] ref_temp;
        logic [CAL_W-1:0] temp_slope;
    } cal_t;

endpackage

@@ design/bc_regs.sv @@
module bc_regs (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [bc_pkg::ADDR_W-1:0]  paddr,
    input  logic [bc_pkg::DATA_W-1:0]  pwdata,
    output logic [bc_pkg::DATA_W-1:0]  prdata,
    output logic                       pready,
    output bc_pkg::cal_t               cal
);
    import bc_pkg::*;

    cal_t             cal_reg;
    cal_t             cal_next;
    logic [IDX_W-1:0] idx;
    logic [CAL_W-1:0] wval;
    logic [CAL_W-1:0] rval;

    assign idx    = paddr[ADDR_W-1:2];
    assign wval   = pwdata[CAL_W-1:0];
    assign pready = 1'b1;
    assign cal    = cal_reg;

    always_comb begin
        cal_next = cal_reg;
        if (psel && penable && pwrite) begin
            case (idx)
                REG_SENS_BASE:     cal_next.sens_base     = wval;
                REG_OFFSET_BASE:   cal_next.offset_base   = wval;
                REG_SENS_TEMPCO:   cal_next.sens_tempco   = wval;
                REG_OFFSET_TEMPCO: cal_next.offset_tempco = wval;
                REG_REF_TEMP:      cal_next.ref_temp      = wval;
                REG_TEMP_SLOPE:    cal_next.temp_slope    = wval;
                default:           cal_next = cal_reg;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_SENS_BASE:     rval = cal_reg.sens_base;
            REG_OFFSET_BASE:   rval = cal_reg.offset_base;
            REG_SENS_TEMPCO:   rval = cal_reg.sens_tempco;
            REG_OFFSET_TEMPCO: rval = cal_reg.offset_tempco;
            REG_REF_TEMP:      rval = cal_reg.ref_temp;
            REG_TEMP_SLOPE:    rval = cal_reg.temp_slope;
            default:           rval = '0;
        endcase
    end

    assign prdata = DATA_W'(rval);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cal_reg.sens_base     <= RST_SENS_BASE;
            cal_reg.offset_base   <= RST_OFFSET_BASE;
            cal_reg.sens_tempco   <= RST_SENS_TEMPCO;
            cal_reg.offset_tempco <= RST_OFFSET_TEMPCO;
            cal_reg.ref_temp      <= RST_REF_TEMP;
            cal_reg.temp_slope    <= RST_TEMP_SLOPE;
        end else begin
            cal_reg <= cal_next;
        end
    end

endmodule

@@ design/bc_temp.sv @@
module bc_temp (
    input  logic                               aclk,
    input  logic [2:0]                         stage_en,
    input  bc_pkg::cal_t                       cal,
    input  logic [bc_pkg::RAW_W-1:0]           raw_temperature,
    input  logic [bc_pkg::RAW_W-1:0]           raw_pressure,
    output logic signed [bc_pkg::DT_W-1:0]     dt,
    output logic [bc_pkg::RAW_W-1:0]           raw_p,
    output logic signed [bc_pkg::TEMP_W-1:0]   temp,
    output logic signed [bc_pkg::OFF_W-1:0]    off,
    output logic signed [bc_pkg::SENS_W-1:0]   sens
);
    import bc_pkg::*;

    // stage 1: temperature difference
    logic signed [DT_W-1:0]   dt1_reg;
    logic signed [DT_W-1:0]   dt1_next;
    logic [RAW_W-1:0]         rp1_reg;

    // stage 2: three products of dt
    logic signed [DT_W-1:0]   dt2_reg;
    logic [RAW_W-1:0]         rp2_reg;
    logic signed [MULT_W-1:0] pt_reg;
    logic signed [MULT_W-1:0] po_reg;
    logic signed [MULT_W-1:0] ps_reg;
    logic signed [MULT_W-1:0] pt_next;
    logic signed [MULT_W-1:0] po_next;
    logic signed [MULT_W-1:0] ps_next;

    // stage 3: first-order temperature, offset, sensitivity
    logic signed [DT_W-1:0]   dt3_reg;
    logic [RAW_W-1:0]         rp3_reg;
    logic signed [TEMP_W-1:0] temp_reg;
    logic signed [OFF_W-1:0]  off_reg;
    logic signed [SENS_W-1:0] sens_reg;
    logic signed [TEMP_W-1:0] temp_next;
    logic signed [OFF_W-1:0]  off_next;
    logic signed [SENS_W-1:0] sens_next;

    always_comb begin
        dt1_next = $signed({1'b0, raw_temperature}) - $signed({1'b0, cal.ref_temp, 8'b0});
        pt_next  = MULT_W'(dt1_reg * $signed({1'b0, cal.temp_slope}));
        po_next  = MULT_W'(dt1_reg * $signed({1'b0, cal.offset_tempco}));
        ps_next  = MULT_W'(dt1_reg * $signed({1'b0, cal.sens_tempco}));
        temp_next = TEMP_W'(pt_reg >>> 23) + TEMP_REF;
        off_next  = OFF_W'($signed({1'b0, cal.offset_base, 16'b0})) + OFF_W'(po_reg >>> 7);
        sens_next = SENS_W'($signed({1'b0, cal.sens_base, 15'b0})) + SENS_W'(ps_reg >>> 8);
    end

    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            dt1_reg <= dt1_next;
            rp1_reg <= raw_pressure;
        end
        if (stage_en[1]) begin
            dt2_reg <= dt1_reg;
            rp2_reg <= rp1_reg;
            pt_reg  <= pt_next;
            po_reg  <= po_next;
            ps_reg  <= ps_next;
        end
        if (stage_en[2]) begin
            dt3_reg  <= dt2_reg;
            rp3_reg  <= rp2_reg;
            temp_reg <= temp_next;
            off_reg  <= off_next;
            sens_reg <= sens_next;
        end
    end

    assign dt    = dt3_reg;
    assign raw_p = rp3_reg;
    assign temp  = temp_reg;
    assign off   = off_reg;
    assign sens  = sens_reg;

endmodule

@@ design/bc_corr.sv @@
module bc_corr (
    input  logic                               aclk,
    input  logic [1:0]                         stage_en,
    input  logic signed [bc_pkg::DT_W-1:0]     dt_in,
    input  logic [bc_pkg::RAW_W-1:0]           raw_p_in,
    input  logic signed [bc_pkg::TEMP_W-1:0]   temp_in,
    input  logic signed [bc_pkg::OFF_W-1:0]    off_in,
    input  logic signed [bc_pkg::SENS_W-1:0]   sens_in,
    output logic signed [bc_pkg::DT_W-1:0]     dt,
    output logic [bc_pkg::RAW_W-1:0]           raw_p,
    output logic signed [bc_pkg::TEMP_W-1:0]   temp,
    output logic signed [bc_pkg::OFF_W-1:0]    off,
    output logic signed [bc_pkg::SENS_W-1:0]   sens
);
    import bc_pkg::*;

    // stage 4: squares of the distances below the two thresholds
    logic signed [DT_W-1:0]   dt4_reg;
    logic [RAW_W-1:0]         rp4_reg;
    logic signed [TEMP_W-1:0] temp4_reg;
    logic signed [OFF_W-1:0]  off4_reg;
    logic signed [SENS_W-1:0] sens4_reg;
    logic [SQ_W-1:0]          sq_reg;
    logic [SQ_W-1:0]          sq2_reg;
    logic                     cold_reg;
    logic                     frigid_reg;
    logic signed [TEMP_W-1:0] d;
    logic signed [TEMP_W-1:0] e;
    logic [SQ_W-1:0]          sq_next;
    logic [SQ_W-1:0]          sq2_next;

    // stage 5: corrected offset and sensitivity
    logic signed [DT_W-1:0]   dt5_reg;
    logic [RAW_W-1:0]         rp5_reg;
    logic signed [TEMP_W-1:0] temp5_reg;
    logic signed [OFF_W-1:0]  off5_reg;
    logic signed [SENS_W-1:0] sens5_reg;
    logic signed [OFF_W-1:0]  off5_next;
    logic signed [SENS_W-1:0] sens5_next;
    logic [CORR_W-1:0]        sqx;
    logic [CORR_W-1:0]        sq2x;
    logic [CORR_W-1:0]        five_sq;
    logic [CORR_W-1:0]        seven_sq2;
    logic [CORR_W-1:0]        eleven_sq2;
    logic [OFF_W-2:0]         off2;
    logic [SENS_W-2:0]        sens2;

    always_comb begin
        d        = temp_in - TEMP_REF;
        e        = temp_in - TEMP_FRIGID;
        sq_next  = SQ_W'(d * d);
        sq2_next = SQ_W'(e * e);
    end

    always_comb begin
        sqx        = CORR_W'(sq_reg);
        sq2x       = CORR_W'(sq2_reg);
        five_sq    = (sqx << 2) + sqx;
        seven_sq2  = (sq2x << 3) - sq2x;
        eleven_sq2 = (sq2x << 3) + (sq2x << 1) + sq2x;
        off2  = '0;
        sens2 = '0;
        if (cold_reg) begin
            off2  = (OFF_W-1)'(five_sq >> 1);
            sens2 = (SENS_W-1)'(five_sq >> 2);
            if (frigid_reg) begin
                off2  = off2 + (OFF_W-1)'(seven_sq2);
                sens2 = sens2 + (SENS_W-1)'(eleven_sq2 >> 1);
            end
        end
        off5_next  = off4_reg - $signed({1'b0, off2});
        sens5_next = sens4_reg - $signed({1'b0, sens2});
    end

    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            dt4_reg    <= dt_in;
            rp4_reg    <= raw_p_in;
            temp4_reg  <= temp_in;
            off4_reg   <= off_in;
            sens4_reg  <= sens_in;
            sq_reg     <= sq_next;
            sq2_reg    <= sq2_next;
            cold_reg   <= temp_in < TEMP_REF;
            frigid_reg <= temp_in < TEMP_FRIGID;
        end
        if (stage_en[1]) begin
            dt5_reg   <= dt4_reg;
            rp5_reg   <= rp4_reg;
            temp5_reg <= temp4_reg;
            off5_reg  <= off5_next;
            sens5_reg <= sens5_next;
        end
    end

    assign dt    = dt5_reg;
    assign raw_p = rp5_reg;
    assign temp  = temp5_reg;
    assign off   = off5_reg;
    assign sens  = sens5_reg;

endmodule

@@ design/bc_press.sv @@
module bc_press (
    input  logic                               aclk,
    input  logic [2:0]                         stage_en,
    input  logic signed [bc_pkg::DT_W-1:0]     dt_in,
    input  logic [bc_pkg::RAW_W-1:0]           raw_p_in,
    input  logic signed [bc_pkg::TEMP_W-1:0]   temp_in,
    input  logic signed [bc_pkg::OFF_W-1:0]    off_in,
    input  logic signed [bc_pkg::SENS_W-1:0]   sens_in,
    output logic signed [bc_pkg::DT_W-1:0]     temp_difference,
    output logic signed [bc_pkg::TEMP_W-1:0]   temperature_centi,
    output logic signed [bc_pkg::PRES_W-1:0]   pressure_pa
);
    import bc_pkg::*;

    // stage 6: two partial products of pressure and sensitivity
    logic signed [DT_W-1:0]   dt6_reg;
    logic signed [TEMP_W-1:0] temp6_reg;
    logic signed [OFF_W-1:0]  off6_reg;
    logic signed [PLO_W-1:0]  plo_reg;
    logic signed [PHI_W-1:0]  phi_reg;
    logic signed [PLO_W-1:0]  plo_next;
    logic signed [PHI_W-1:0]  phi_next;

    // stage 7: full product
    logic signed [DT_W-1:0]   dt7_reg;
    logic signed [TEMP_W-1:0] temp7_reg;
    logic signed [OFF_W-1:0]  off7_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;

    // stage 8: output register
    logic signed [DT_W-1:0]   dt8_reg;
    logic signed [TEMP_W-1:0] temp8_reg;
    logic signed [PRES_W-1:0] pres_reg;
    logic signed [PROD_W-1:0] diff;

    always_comb begin
        plo_next  = PLO_W'($signed({1'b0, raw_p_in}) * $signed({1'b0, sens_in[LO_W-1:0]}));
        phi_next  = PHI_W'($signed({1'b0, raw_p_in}) * $signed(sens_in[SENS_W-1:LO_W]));
        prod_next = (PROD_W'(phi_reg) <<< LO_W) + PROD_W'(plo_reg);
        diff      = (prod_reg >>> 21) - PROD_W'(off7_reg);
    end

    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            dt6_reg   <= dt_in;
            temp6_reg <= temp_in;
            off6_reg  <= off_in;
            plo_reg   <= plo_next;
            phi_reg   <= phi_next;
        end
        if (stage_en[1]) begin
            dt7_reg   <= dt6_reg;
            temp7_reg <= temp6_reg;
            off7_reg  <= off6_reg;
            prod_reg  <= prod_next;
        end
        if (stage_en[2]) begin
            dt8_reg   <= dt7_reg;
            temp8_reg <= temp7_reg;
            pres_reg  <= diff[PRES_W+14:15];
        end
    end

    assign temp_difference   = dt8_reg;
    assign temperature_centi = temp8_reg;
    assign pressure_pa       = pres_reg;

endmodule

@@ design/barometer_compensation.sv @@
// Compensates one raw temperature/pressure pair per request and returns the temperature
// difference, the temperature in hundredths of a degree and the pressure in pascals, with
// the first- and second-order low-temperature corrections applied. The datapath is an
// eight-stage pipeline: m_valid rises once a request reaches the last stage, and a new
// request is taken every cycle while s_ready is high. Each stage holds when the stage
// after it is full and stalled, so s_ready drops only once every stage holds an
// unaccepted result. The user must write calibration words over the APB port only while
// no request is in flight; the block itself does not enforce this.
module barometer_compensation (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [bc_pkg::ADDR_W-1:0]          paddr,
    input  logic [bc_pkg::DATA_W-1:0]          pwdata,
    output logic [bc_pkg::DATA_W-1:0]          prdata,
    output logic                               pready,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [bc_pkg::RAW_W-1:0]           s_raw_temperature,
    input  logic [bc_pkg::RAW_W-1:0]           s_raw_pressure,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [bc_pkg::DT_W-1:0]     m_temp_difference,
    output logic signed [bc_pkg::TEMP_W-1:0]   m_temperature_centi,
    output logic signed [bc_pkg::PRES_W-1:0]   m_pressure_pa
);
    import bc_pkg::*;

    cal_t                     cal;
    logic [PIPE_STAGES-1:0]   valid_reg;
    logic [PIPE_STAGES-1:0]   valid_next;
    logic [PIPE_STAGES-1:0]   en;
    logic                     in_acc;
    logic                     out_acc;

    logic signed [DT_W-1:0]   t_dt;
    logic [RAW_W-1:0]         t_rp;
    logic signed [TEMP_W-1:0] t_temp;
    logic signed [OFF_W-1:0]  t_off;
    logic signed [SENS_W-1:0] t_sens;
    logic signed [DT_W-1:0]   c_dt;
    logic [RAW_W-1:0]         c_rp;
    logic signed [TEMP_W-1:0] c_temp;
    logic signed [OFF_W-1:0]  c_off;
    logic signed [SENS_W-1:0] c_sens;

    // a stage advances when it is empty or the stage after it advances
    always_comb begin
        en[PIPE_STAGES-1] = !valid_reg[PIPE_STAGES-1] || m_ready;
        for (int i = PIPE_STAGES - 2; i >= 0; i--) begin
            en[i] = !valid_reg[i] || en[i+1];
        end
    end

    always_comb begin
        valid_next = valid_reg;
        if (en[0]) begin
            valid_next[0] = s_valid;
        end
        for (int i = 1; i < PIPE_STAGES; i++) begin
            if (en[i]) begin
                valid_next[i] = valid_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign s_ready = en[0];
    assign m_valid = valid_reg[PIPE_STAGES-1];
    assign in_acc  = s_valid && s_ready;
    assign out_acc = m_valid && m_ready;

    bc_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cal     (cal)
    );

    bc_temp u_temp (
        .aclk            (aclk),
        .stage_en        (en[2:0]),
        .cal             (cal),
        .raw_temperature (s_raw_temperature),
        .raw_pressure    (s_raw_pressure),
        .dt              (t_dt),
        .raw_p           (t_rp),
        .temp            (t_temp),
        .off             (t_off),
        .sens            (t_sens)
    );

    bc_corr u_corr (
        .aclk     (aclk),
        .stage_en (en[4:3]),
        .dt_in    (t_dt),
        .raw_p_in (t_rp),
        .temp_in  (t_temp),
        .off_in   (t_off),
        .sens_in  (t_sens),
        .dt       (c_dt),
        .raw_p    (c_rp),
        .temp     (c_temp),
        .off      (c_off),
        .sens     (c_sens)
    );

    bc_press u_press (
        .aclk              (aclk),
        .stage_en          (en[7:5]),
        .dt_in             (c_dt),
        .raw_p_in          (c_rp),
        .temp_in           (c_temp),
        .off_in            (c_off),
        .sens_in           (c_sens),
        .temp_difference   (m_temp_difference),
        .temperature_centi (m_temperature_centi),
        .pressure_pa       (m_pressure_pa)
    );

    // backpressure reaches the input only when every stage is occupied
    a_full_when_blocked: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (&valid_reg))
        else $error("input blocked while the pipeline has a free stage");

    a_enter: assert property (@(posedge aclk) disable iff (!aresetn)
        in_acc |=> valid_reg[0])
        else $error("accepted request did not enter the first stage");

    // requests in flight change only by what enters and what leaves
    a_conserve: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |->
        ($countones(valid_reg) + int'($past(out_acc))
            == $past($countones(valid_reg)) + int'($past(in_acc))))
        else $error("request lost or duplicated inside the pipeline");

endmodule
